// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/pcth_pkg.sv -----
// ----------------------------------------------------------------------------
// Point cloud top/side histogram package
// Widths, constants, state codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package pcth_pkg;

   localparam int MaxRows = 256;
   localparam int MaxCols = 512;
   localparam int RowW    = $clog2(MaxRows);
   localparam int ColW    = $clog2(MaxCols);
   localparam int AddrW   = RowW + ColW;
   localparam int CountW  = 18;
   localparam logic [CountW-1:0] CountSat = 18'd131072;

   localparam int MaxZW   = 15;
   localparam int RowsW   = 9;
   localparam int ColsW   = 10;
   localparam int CoordW  = 16;
   localparam int NumW    = 30;
   localparam int DenW    = MaxZW + 1;
   localparam int DivCntW = $clog2(NumW + 1);
   localparam int IdxW    = 2;
   localparam int JobW    = 2;

   localparam logic [IdxW-1:0] RegMaxZ = 2'd0;
   localparam logic [IdxW-1:0] RegRows = 2'd1;
   localparam logic [IdxW-1:0] RegCols = 2'd2;

   localparam logic [JobW-1:0] JobTopCol  = 2'd0;
   localparam logic [JobW-1:0] JobTopRow  = 2'd1;
   localparam logic [JobW-1:0] JobSideCol = 2'd2;
   localparam logic [JobW-1:0] JobSideRow = 2'd3;

   localparam logic [MaxZW-1:0] ResetMaxZ = 15'd4000;
   localparam logic [RowsW-1:0] ResetRows = 9'd240;
   localparam logic [ColsW-1:0] ResetCols = 10'd320;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_MUL    = 9'b000000100,
      ST_LOAD   = 9'b000001000,
      ST_DIV    = 9'b000010000,
      ST_STORE  = 9'b000100000,
      ST_MEM_RD = 9'b001000000,
      ST_MEM_WR = 9'b010000000,
      ST_RESP   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic            clr;
      logic            capture;
      logic            mul;
      logic            load;
      logic            div_step;
      logic            store;
      logic            mem_rd;
      logic            mem_wr;
      logic [JobW-1:0] job;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mode_rd;
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/pcth_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pcth_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire logic                      step,
   input  wire logic [pcth_pkg::NumW-1:0] num,
   input  wire logic [pcth_pkg::DenW-1:0] den,
   output logic      [pcth_pkg::NumW-1:0] quot,
   output logic                           done
);
   import pcth_pkg::*;

   logic [DenW-1:0]    rem_ff, rem_in;
   logic [NumW-1:0]    quo_ff, quo_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [DenW:0]      trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[NumW-1]};
      if (load) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = DivCntW'(NumW);
      end else if (step && cnt_ff != '0) begin
         if (trial >= {1'b0, den}) begin
            rem_in = DenW'(trial - {1'b0, den});
            quo_in = {quo_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial[DenW-1:0];
            quo_in = {quo_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quot = quo_ff;
   assign done = (cnt_ff == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/pcth_ctrl.sv -----
// ----------------------------------------------------------------------------
// Histogram controller
// Sequences clearing, projection divisions and bin updates.
// ----------------------------------------------------------------------------
`default_nettype none

module pcth_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_valid,
   output pcth_pkg::cmd_type      cmd,
   input  wire pcth_pkg::sts_type sts
);
   import pcth_pkg::*;

   state_type       state_ff, state_in;
   logic [JobW-1:0] job_ff, job_in;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.job  = job_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               job_in      = JobTopCol;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.mode_rd ? ST_MEM_RD : ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_STORE;
            else cmd.div_step = 1'b1;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            job_in    = job_ff + 1'b1;
            state_in  = (job_ff == JobSideRow) ? ST_MEM_RD : ST_MUL;
         end
         ST_MEM_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_MEM_WR;
         end
         ST_MEM_WR: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         job_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

`default_nettype wire

// ----- hw/rtl/pcth_datapath.sv -----
// ----------------------------------------------------------------------------
// Histogram datapath
// Registers, projection arithmetic, divider and the two count memories.
// ----------------------------------------------------------------------------
`default_nettype none

module pcth_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pcth_pkg::cmd_type                 cmd,
   output pcth_pkg::sts_type                      sts,
   input  wire logic                              csr_we,
   input  wire logic [pcth_pkg::IdxW-1:0]         csr_index,
   input  wire logic [pcth_pkg::MaxZW-1:0]        csr_wdata,
   input  wire logic                              req_mode,
   input  wire logic signed [pcth_pkg::CoordW-1:0] req_point_x_mm,
   input  wire logic signed [pcth_pkg::CoordW-1:0] req_point_y_mm,
   input  wire logic signed [pcth_pkg::CoordW-1:0] req_point_z_mm,
   input  wire logic [pcth_pkg::RowW-1:0]         req_bin_row,
   input  wire logic [pcth_pkg::ColW-1:0]         req_bin_col,
   output logic                                   rsp_top_hit,
   output logic                                   rsp_side_hit,
   output logic [pcth_pkg::CountW-1:0]            rsp_top_count,
   output logic [pcth_pkg::CountW-1:0]            rsp_side_count
);
   import pcth_pkg::*;

   logic [MaxZW-1:0] max_z_ff;
   logic [RowsW-1:0] rows_ff;
   logic [ColsW-1:0] cols_ff;

   logic                     mode_ff;
   logic signed [CoordW-1:0] x_ff, y_ff, z_ff;
   logic [RowW-1:0]          bin_row_ff;
   logic [ColW-1:0]          bin_col_ff;

   logic signed [18:0] m19, x19, y19, z19, b19;
   logic signed [10:0] diff, diff_adj, shift;
   logic signed [28:0] a29, b29, c29, d29;
   logic signed [28:0] p1_ff, p2_ff;
   logic signed [NumW-1:0] sum;
   logic [NumW-1:0]   mag;
   logic [DenW-1:0]   den;
   logic [NumW-1:0]   quot;
   logic              div_done;
   logic              neg_ff;
   logic [NumW-1:0]   res_q_ff   [0:3];
   logic              res_neg_ff [0:3];
   logic              z_ok, y_ok;
   logic [NumW-1:0]   top_col_v, top_row_v, side_col_v, side_row_v;

   logic [AddrW-1:0]  clr_addr_ff;
   logic [AddrW-1:0]  top_addr_in, side_addr_in, top_addr_ff, side_addr_ff;
   logic              top_ok_in, side_ok_in, top_ok_ff, side_ok_ff;
   logic [CountW-1:0] top_rd_ff, side_rd_ff;
   logic [CountW-1:0] top_wdata, side_wdata;
   logic [AddrW-1:0]  top_waddr, side_waddr;
   logic              top_we, side_we;
   logic [CountW-1:0] top_mem  [0:(1 << AddrW)-1];
   logic [CountW-1:0] side_mem [0:(1 << AddrW)-1];

   logic              top_hit_ff, side_hit_ff;
   logic [CountW-1:0] top_count_ff, side_count_ff;

   function automatic logic bin_ok(input logic [NumW-1:0] q, input logic neg,
                                   input logic [NumW-1:0] lim, input logic [NumW-1:0] cap);
      logic [NumW-1:0] eff;
      eff = neg ? '0 : q;
      return (!neg || q == '0) && (eff < lim) && (eff < cap);
   endfunction

   function automatic logic [NumW-1:0] bin_val(input logic [NumW-1:0] q, input logic neg);
      return neg ? '0 : q;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         max_z_ff <= ResetMaxZ;
         rows_ff  <= ResetRows;
         cols_ff  <= ResetCols;
      end else if (csr_we) begin
         unique case (csr_index)
            RegMaxZ: max_z_ff <= csr_wdata;
            RegRows: rows_ff  <= csr_wdata[RowsW-1:0];
            RegCols: cols_ff  <= csr_wdata[ColsW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (cmd.capture) begin
         mode_ff <= req_mode;
      end
      if (cmd.capture) begin
         x_ff       <= req_point_x_mm;
         y_ff       <= req_point_y_mm;
         z_ff       <= req_point_z_mm;
         bin_row_ff <= req_bin_row;
         bin_col_ff <= req_bin_col;
      end
   end

   assign m19 = $signed({4'b0, max_z_ff});
   assign x19 = $signed({{3{x_ff[CoordW-1]}}, x_ff});
   assign y19 = $signed({{3{y_ff[CoordW-1]}}, y_ff});
   assign z19 = $signed({{3{z_ff[CoordW-1]}}, z_ff});

   assign diff     = $signed({1'b0, cols_ff}) - $signed({2'b0, rows_ff});
   assign diff_adj = diff + $signed({10'b0, diff[10]});
   assign shift    = diff_adj >>> 1;

   assign z_ok = (z19 > 19'sd0) && (z19 < m19);
   assign y_ok = ($signed({y19[17:0], 1'b0}) > -m19) && ($signed({y19[17:0], 1'b0}) < m19);

   always_comb begin
      b19 = 19'sd0;
      c29 = 29'sd0;
      den = {1'b0, max_z_ff};
      case (cmd.job)
         JobTopCol: begin
            b19 = m19 + $signed({x19[17:0], 1'b0});
            c29 = $signed({13'b0, max_z_ff, 1'b0});
            den = {max_z_ff, 1'b0};
         end
         JobTopRow: begin
            b19 = m19 - z19;
         end
         JobSideCol: begin
            b19 = z19;
            c29 = $signed({14'b0, max_z_ff});
         end
         default: begin
            b19 = m19 + $signed({y19[17:0], 1'b0});
            den = {max_z_ff, 1'b0};
         end
      endcase
   end

   assign a29 = $signed({20'b0, rows_ff});
   assign b29 = $signed({{10{b19[18]}}, b19});
   assign d29 = $signed({{18{shift[10]}}, shift});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         p1_ff <= a29 * b29;
         p2_ff <= c29 * d29;
      end
   end

   assign sum = $signed({p1_ff[28], p1_ff}) + $signed({p2_ff[28], p2_ff});
   assign mag = sum[NumW-1] ? NumW'(-sum) : NumW'(sum);

   always_ff @(posedge clock) begin
      if (cmd.load) neg_ff <= sum[NumW-1];
   end

   pcth_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (cmd.load),
      .step  (cmd.div_step),
      .num   (mag),
      .den   (den),
      .quot  (quot),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         res_q_ff[cmd.job]   <= quot;
         res_neg_ff[cmd.job] <= neg_ff;
      end
   end

   assign top_col_v  = bin_val(res_q_ff[JobTopCol], res_neg_ff[JobTopCol]);
   assign top_row_v  = bin_val(res_q_ff[JobTopRow], res_neg_ff[JobTopRow]);
   assign side_col_v = bin_val(res_q_ff[JobSideCol], res_neg_ff[JobSideCol]);
   assign side_row_v = bin_val(res_q_ff[JobSideRow], res_neg_ff[JobSideRow]);

   always_comb begin
      if (mode_ff) begin
         top_addr_in  = {bin_row_ff, bin_col_ff};
         side_addr_in = {bin_row_ff, bin_col_ff};
         top_ok_in    = 1'b1;
         side_ok_in   = 1'b1;
      end else begin
         top_addr_in  = {top_row_v[RowW-1:0], top_col_v[ColW-1:0]};
         side_addr_in = {side_row_v[RowW-1:0], side_col_v[ColW-1:0]};
         top_ok_in    = z_ok
            && bin_ok(res_q_ff[JobTopRow], res_neg_ff[JobTopRow],
                      NumW'(rows_ff), NumW'(MaxRows))
            && bin_ok(res_q_ff[JobTopCol], res_neg_ff[JobTopCol],
                      NumW'(cols_ff), NumW'(MaxCols));
         side_ok_in   = z_ok && y_ok
            && bin_ok(res_q_ff[JobSideRow], res_neg_ff[JobSideRow],
                      NumW'(rows_ff), NumW'(MaxRows))
            && bin_ok(res_q_ff[JobSideCol], res_neg_ff[JobSideCol],
                      NumW'(cols_ff), NumW'(MaxCols));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         top_addr_ff  <= top_addr_in;
         side_addr_ff <= side_addr_in;
         top_ok_ff    <= top_ok_in;
         side_ok_ff   <= side_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_comb begin
      top_waddr  = cmd.clr ? clr_addr_ff : top_addr_ff;
      side_waddr = cmd.clr ? clr_addr_ff : side_addr_ff;
      top_we     = cmd.clr || (cmd.mem_wr && top_ok_ff);
      side_we    = cmd.clr || (cmd.mem_wr && side_ok_ff);
      if (cmd.clr || mode_ff) begin
         top_wdata  = '0;
         side_wdata = '0;
      end else begin
         top_wdata  = (top_rd_ff < CountSat) ? top_rd_ff + 1'b1 : top_rd_ff;
         side_wdata = (side_rd_ff < CountSat) ? side_rd_ff + 1'b1 : side_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (top_we) top_mem[top_waddr] <= top_wdata;
      if (cmd.mem_rd) top_rd_ff <= top_mem[top_addr_in];
   end

   always_ff @(posedge clock) begin
      if (side_we) side_mem[side_waddr] <= side_wdata;
      if (cmd.mem_rd) side_rd_ff <= side_mem[side_addr_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         top_hit_ff    <= !mode_ff && top_ok_ff;
         side_hit_ff   <= !mode_ff && side_ok_ff;
         top_count_ff  <= mode_ff ? top_rd_ff : '0;
         side_count_ff <= mode_ff ? side_rd_ff : '0;
      end
   end

   assign sts.clear_last = (clr_addr_ff == '1);
   assign sts.mode_rd    = mode_ff;
   assign sts.div_done   = div_done;

   assign rsp_top_hit    = top_hit_ff;
   assign rsp_side_hit   = side_hit_ff;
   assign rsp_top_count  = top_count_ff;
   assign rsp_side_count = side_count_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/point_cloud_top_side_histogram.sv -----
// ----------------------------------------------------------------------------
// Point cloud top and side view histogram
// Projects points into two saturating count maps and reads/clears bins.
// ----------------------------------------------------------------------------
// Channel        Ports                         Transfer
// request        start, busy, req_*            start high while busy low
// response       rsp_valid, rsp_*              one cycle strobe, no stall
// configuration  csr_we, csr_index, csr_wdata  csr_we high
//
// A point passes the accept, four projections (each a multiply, a load, 30
// restoring division steps, a check that sees them done and a store), then a
// read-modify-write of both count memories and the response. A bin read and
// clear passes the multiply state, a read and a write of both memories and
// the response. After reset both memories are cleared at one entry per cycle,
// with busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module point_cloud_top_side_histogram (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_mode,
   input  wire logic signed [pcth_pkg::CoordW-1:0] req_point_x_mm,
   input  wire logic signed [pcth_pkg::CoordW-1:0] req_point_y_mm,
   input  wire logic signed [pcth_pkg::CoordW-1:0] req_point_z_mm,
   input  wire logic [pcth_pkg::RowW-1:0]          req_bin_row,
   input  wire logic [pcth_pkg::ColW-1:0]          req_bin_col,
   output logic                                    rsp_valid,
   output logic                                    rsp_top_hit,
   output logic                                    rsp_side_hit,
   output logic [pcth_pkg::CountW-1:0]             rsp_top_count,
   output logic [pcth_pkg::CountW-1:0]             rsp_side_count,
   input  wire logic                               csr_we,
   input  wire logic [pcth_pkg::IdxW-1:0]          csr_index,
   input  wire logic [pcth_pkg::MaxZW-1:0]         csr_wdata
);
   import pcth_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pcth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   pcth_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_mode       (req_mode),
      .req_point_x_mm (req_point_x_mm),
      .req_point_y_mm (req_point_y_mm),
      .req_point_z_mm (req_point_z_mm),
      .req_bin_row    (req_bin_row),
      .req_bin_col    (req_bin_col),
      .rsp_top_hit    (rsp_top_hit),
      .rsp_side_hit   (rsp_side_hit),
      .rsp_top_count  (rsp_top_count),
      .rsp_side_count (rsp_side_count)
   );

   `ASSERT_SAME_CYCLE(a_rsp_busy, clock, reset, rsp_valid, busy, "response while idle")
   `ASSERT_NEXT_CYCLE(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "repeated response")
   `ASSERT_NEXT_CYCLE(a_accept_busy, clock, reset, start && !busy, busy, "accept not taken")
   `ASSERT_SAME_CYCLE(a_hit_no_count, clock, reset, rsp_valid && (rsp_top_hit || rsp_side_hit),
      rsp_top_count == '0 && rsp_side_count == '0, "hit and count together")

endmodule

`default_nettype wire

// ----- test/tb_point_cloud_top_side_histogram.sv -----
// ----------------------------------------------------------------------------
// Point cloud top and side view histogram testbench
// Drives points and bin reads through the request port under several register
// settings and idle patterns. A local model of both count maps predicts every
// response, and each response strobe is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_point_cloud_top_side_histogram;
   import pcth_pkg::*;

   typedef struct {
      bit              top_hit;
      bit              side_hit;
      bit [CountW-1:0] top_count;
      bit [CountW-1:0] side_count;
   } hist_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_mode = 1'b0;
   logic signed [CoordW-1:0] req_point_x_mm = '0;
   logic signed [CoordW-1:0] req_point_y_mm = '0;
   logic signed [CoordW-1:0] req_point_z_mm = '0;
   logic [RowW-1:0]          req_bin_row = '0;
   logic [ColW-1:0]          req_bin_col = '0;
   logic                     rsp_valid;
   logic                     rsp_top_hit;
   logic                     rsp_side_hit;
   logic [CountW-1:0]        rsp_top_count;
   logic [CountW-1:0]        rsp_side_count;
   logic                     csr_we = 1'b0;
   logic [IdxW-1:0]          csr_index = '0;
   logic [MaxZW-1:0]         csr_wdata = '0;

   point_cloud_top_side_histogram dut (.*);

   always #5 clock = ~clock;

   bit [CountW-1:0] top_map[int];
   bit [CountW-1:0] side_map[int];
   int              hit_bins[$];
   hist_result_type pending_results[$];
   longint          depth_scale = ResetMaxZ;
   longint          rows_used = ResetRows;
   longint          cols_used = ResetCols;
   int              send_idle_pct = 0;
   int              errors = 0;
   int              checked = 0;
   int              points_sent = 0;
   int              reads_sent = 0;

   function automatic bit bump_bin(bit is_top, longint row, longint col);
      int key;
      if (row < 0 || col < 0 || row >= rows_used || col >= cols_used) return 0;
      if (row >= MaxRows || col >= MaxCols) return 0;
      key = int'(row * MaxCols + col);
      if (is_top) begin
         if (!top_map.exists(key)) top_map[key] = '0;
         if (top_map[key] < CountSat) top_map[key]++;
      end else begin
         if (!side_map.exists(key)) side_map[key] = '0;
         if (side_map[key] < CountSat) side_map[key]++;
      end
      hit_bins.push_back(key);
      return 1;
   endfunction

   function automatic hist_result_type project_point(bit mode, longint x, longint y, longint z,
                                                     int row, int col);
      hist_result_type res;
      longint          m;
      longint          rr;
      longint          shift;
      int              key;
      res = '{0, 0, 0, 0};
      m = depth_scale;
      rr = rows_used;
      shift = (cols_used - rr) / 2;
      if (mode) begin
         key = row * MaxCols + col;
         if (top_map.exists(key)) res.top_count = top_map[key];
         if (side_map.exists(key)) res.side_count = side_map[key];
         top_map.delete(key);
         side_map.delete(key);
      end else if (z > 0 && z < m) begin
         res.top_hit = bump_bin(1, (rr * (m - z)) / m,
                                (rr * (m + 2 * x) + 2 * m * shift) / (2 * m));
         if (2 * y > -m && 2 * y < m)
            res.side_hit = bump_bin(0, (rr * (m + 2 * y)) / (2 * m),
                                    (rr * z + m * shift) / m);
      end
      return res;
   endfunction

   task automatic send_item(bit mode, int x, int y, int z, int row, int col);
      int gap;
      gap = 0;
      req_mode <= mode;
      req_point_x_mm <= CoordW'(x);
      req_point_y_mm <= CoordW'(y);
      req_point_z_mm <= CoordW'(z);
      req_bin_row <= RowW'(row);
      req_bin_col <= ColW'(col);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(project_point(mode, longint'(CoordW'(x) & 16'hFFFF) -
                                (x[15] ? 65536 : 0), $signed(16'(y)), $signed(16'(z)),
                                row & 8'hFF, col & 9'h1FF));
      if (mode) reads_sent++; else points_sent++;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_regs(int max_z, int rows, int cols);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= RegMaxZ;
      csr_wdata <= MaxZW'(max_z);
      @(posedge clock);
      depth_scale = max_z & 16'h7FFF;
      csr_index <= RegRows;
      csr_wdata <= MaxZW'(rows);
      @(posedge clock);
      rows_used = rows & 9'h1FF;
      csr_index <= RegCols;
      csr_wdata <= MaxZW'(cols);
      @(posedge clock);
      cols_used = cols & 10'h3FF;
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      hist_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected response transaction at %0t", $realtime);
         end else begin
            want = pending_results.pop_front();
            checked++;
            if (rsp_top_hit !== want.top_hit || rsp_side_hit !== want.side_hit ||
                rsp_top_count !== want.top_count || rsp_side_count !== want.side_count) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch at %0t: expected hit %0d/%0d count %0d/%0d, got %0d/%0d %0d/%0d",
                           $realtime, want.top_hit, want.side_hit, want.top_count,
                           want.side_count, rsp_top_hit, rsp_side_hit, rsp_top_count,
                           rsp_side_count);
            end
         end
      end
   end

   task automatic test_default_settings();
      send_item(0, 0, 0, 2000, 0, 0);
      send_item(0, 0, 0, 2000, 0, 0);
      send_item(1, 0, 0, 0, 120, 160);
      send_item(1, 0, 0, 0, 120, 160);
      send_item(0, -32768, -32768, -32768, 0, 0);
      send_item(0, 32767, 32767, 32767, 0, 0);
      send_item(0, 0, 0, 0, 0, 0);
      send_item(0, 0, 0, 1, 0, 0);
      send_item(0, 0, 1999, 3999, 0, 0);
      send_item(0, 0, -2000, 4000, 0, 0);
      send_item(0, -2000, 2000, 1000, 0, 0);
      send_item(0, 1999, -1999, 3000, 0, 0);
      send_item(1, 0, 0, 0, 255, 511);
      send_item(1, 0, 0, 0, 0, 0);
   endtask

   task automatic test_register_extremes();
      write_regs(1, 256, 512);
      send_item(0, 0, 0, 1, 0, 0);
      write_regs(32767, 256, 512);
      send_item(0, 32767, 16383, 32766, 0, 0);
      send_item(0, -16383, -16383, 1, 0, 0);
      send_item(1, 0, 0, 0, 255, 511);
      write_regs(0, 1, 1);
      send_item(0, 0, 0, 100, 0, 0);
      write_regs(2000, 1, 1);
      send_item(0, -1000, -1000, 1999, 0, 0);
      send_item(1, 0, 0, 0, 0, 0);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= 2'd3;
      csr_wdata <= '1;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_random_traffic(int idle_pct, int count);
      int m;
      int key;
      send_idle_pct = idle_pct;
      for (int blk = 0; blk < 4; blk++) begin
         m = ($urandom_range(3) == 0) ? $urandom_range(32767, 1) : $urandom_range(2000, 50);
         write_regs(m, $urandom_range(256, 1), $urandom_range(512, 1));
         for (int i = 0; i < count / 4; i++) begin
            if ($urandom_range(99) < 60) begin
               if ($urandom_range(99) < 15)
                  send_item(0, $urandom, $urandom, $urandom, $urandom, $urandom);
               else
                  send_item(0, $urandom_range(2 * m, 0) - m, $urandom_range(2 * m, 0) - m,
                            $urandom_range(m > 1 ? m - 1 : 1, 1), $urandom, $urandom);
            end else if (hit_bins.size() != 0 && $urandom_range(99) < 70) begin
               key = hit_bins[$urandom_range(hit_bins.size() - 1)];
               send_item(1, $urandom, $urandom, $urandom, key / MaxCols, key % MaxCols);
            end else begin
               send_item(1, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_settings();
      test_register_extremes();
      test_random_traffic(21, 616);
      test_random_traffic(86, 616);
      test_random_traffic(0, 616);
      wait_idle();
      repeat (200) @(posedge clock);
      $display("Covered %0d points and %0d bin reads, %0d responses checked.",
               points_sent, reads_sent, checked);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Timeout waiting for the histogram to finish.");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pcth_pkg.sv
hw/rtl/pcth_div.sv
hw/rtl/pcth_ctrl.sv
hw/rtl/pcth_datapath.sv
hw/rtl/point_cloud_top_side_histogram.sv
test/tb_point_cloud_top_side_histogram.sv
